// ===== hdl/bece_pkg.sv =====
// package for the burst ecc encoder/decoder
// types, stage words, column unpacking and search helpers
// no dependencies
`timescale 1ns / 1ps

package bece_pkg;

  localparam int CODE_BITS    = 18;
  localparam int CHECK_BITS   = 6;
  localparam int DATA_BITS    = 12;
  localparam int SLOT_W       = 6;
  localparam int COLS_PER_REG = 9;
  localparam int REG_W        = SLOT_W * COLS_PER_REG;

  typedef logic [CHECK_BITS-1:0] col_t;
  typedef col_t [CODE_BITS-1:0]  cols_t;
  typedef logic [CODE_BITS-1:0]  code_t;
  typedef logic [DATA_BITS-1:0]  data_t;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_H_LOW  = 1'b0,
    REG_H_HIGH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    cmd_e  cmd;
    code_t word;
    col_t  syn;
  } s1_t;

  typedef struct packed {
    cmd_e                  cmd;
    code_t                 word;
    col_t                  syn;
    logic [CHECK_BITS-1:0] chk;
    code_t                 m_single;
    code_t                 m_pair;
    code_t                 m_101;
    code_t                 m_111;
  } s2_t;

  typedef struct packed {
    code_t       cword;
    data_t       data;
    logic [5:0]  syndrome;
    logic        uncorrectable;
  } res_t;

  function automatic cols_t cols_from_regs(input logic [REG_W-1:0] lo,
                                           input logic [REG_W-1:0] hi);
    cols_t c;
    for (int k = 0; k < CODE_BITS; k++) begin
      if (k < COLS_PER_REG) begin
        c[k] = lo[SLOT_W*k +: CHECK_BITS];
      end else begin
        c[k] = hi[SLOT_W*(k-COLS_PER_REG) +: CHECK_BITS];
      end
    end
    return c;
  endfunction

  // lowest set bit only
  function automatic code_t first_one(input code_t v);
    return v & (~v + {{(CODE_BITS-1){1'b0}}, 1'b1});
  endfunction

endpackage

// ===== hdl/bece_syndrome.sv =====
// stage 1: forms the code word and the xor of the columns of its set bits
// depends on bece_pkg
`timescale 1ns / 1ps

module bece_syndrome import bece_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cols_t    cols_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     command_i,
  input  data_t    data_word_i,
  input  code_t    received_word_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output s1_t      out_o
);

  logic valid_q;
  s1_t  stage_d, stage_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = stage_q;

  always_comb begin
    stage_d.cmd  = cmd_e'(command_i);
    stage_d.word = (stage_d.cmd == CMD_DECODE) ? received_word_i
                                               : {data_word_i, {CHECK_BITS{1'b0}}};
    stage_d.syn  = '0;
    for (int k = 0; k < CODE_BITS; k++) begin
      if (stage_d.word[k]) begin
        stage_d.syn = stage_d.syn ^ cols_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_q <= stage_d;
    end
  end

endmodule

// ===== hdl/bece_match.sv =====
// stage 2: column pattern compares against the syndrome and encoder check bits
// depends on bece_pkg
`timescale 1ns / 1ps

module bece_match import bece_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cols_t cols_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  s1_t   in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output s2_t   out_o
);

  logic valid_q;
  s2_t  stage_d, stage_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = stage_q;

  always_comb begin
    stage_d.cmd      = in_i.cmd;
    stage_d.word     = in_i.word;
    stage_d.syn      = in_i.syn;
    stage_d.m_single = '0;
    stage_d.m_pair   = '0;
    stage_d.m_101    = '0;
    stage_d.m_111    = '0;
    for (int i = 0; i < CHECK_BITS; i++) begin
      stage_d.chk[i] = ^(cols_i[i] & in_i.syn);
    end
    for (int i = 0; i < CODE_BITS; i++) begin
      stage_d.m_single[i] = (cols_i[i] == in_i.syn);
    end
    for (int i = 1; i < CODE_BITS; i++) begin
      stage_d.m_pair[i] = ((cols_i[i-1] ^ cols_i[i]) == in_i.syn);
    end
    for (int i = 2; i < CODE_BITS; i++) begin
      stage_d.m_101[i] = ((cols_i[i-2] ^ cols_i[i]) == in_i.syn);
      stage_d.m_111[i] = ((cols_i[i-2] ^ cols_i[i-1] ^ cols_i[i]) == in_i.syn);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_q <= stage_d;
    end
  end

endmodule

// ===== hdl/bece_correct.sv =====
// stage 3: first-match selection, error mask, correction and result word
// depends on bece_pkg
`timescale 1ns / 1ps

module bece_correct import bece_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  s2_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  logic  valid_q;
  res_t  res_d, res_q;
  code_t f_single, f_pair, f_101, f_111;
  code_t err, fixed;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_comb begin
    f_single = first_one(in_i.m_single);
    f_pair   = first_one(in_i.m_pair);
    f_101    = first_one(in_i.m_101);
    f_111    = first_one(in_i.m_111);
    // later searches are ORed onto earlier ones, 101 clears its middle bit
    err = f_single | f_pair | (f_pair >> 1);
    err = (err & ~(f_101 >> 1)) | f_101 | (f_101 >> 2);
    err = err | f_111 | (f_111 >> 1) | (f_111 >> 2);
    fixed = in_i.word ^ err;
    if (in_i.cmd == CMD_DECODE) begin
      res_d.cword         = fixed;
      res_d.data          = fixed[CODE_BITS-1:CHECK_BITS];
      res_d.syndrome      = 6'(in_i.syn);
      res_d.uncorrectable = (err[CODE_BITS-1:CHECK_BITS] == '0) && (in_i.syn != '0);
    end else begin
      res_d.cword         = {in_i.word[CODE_BITS-1:CHECK_BITS], in_i.chk};
      res_d.data          = '0;
      res_d.syndrome      = '0;
      res_d.uncorrectable = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== hdl/bece_out.sv =====
// output register with skid entry, upstream ready is registered
// depends on bece_pkg
`timescale 1ns / 1ps

module bece_out import bece_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  logic out_v_q, skid_v_q;
  res_t out_q, skid_q;

  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_ready_i || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= in_valid_i;
      end
    end else if (in_valid_i && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_v_q) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (in_valid_i) begin
        out_q <= in_i;
      end
    end else if (in_valid_i && !skid_v_q) begin
      skid_q <= in_i;
    end
  end

endmodule

// ===== hdl/burst_ecc_encode_decode.sv =====
// top level of the (18,12) burst ecc encoder/decoder with programmable check matrix
// depends on bece_pkg, bece_syndrome, bece_match, bece_correct, bece_out
//
// channel  direction  handshake                  payload
// in       sink       in_valid_i / in_ready_o    command_i, data_word_i, received_word_i
// out      source     out_valid_o / out_ready_i  code_word_out_o, data_out_o, syndrome_o,
//                                                uncorrectable_o
// cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one word per cycle while out_ready_i stays high; an accepted word reaches out_valid_o
// through syndrome xor, column compares, first-match and correct, output register
// reset clears all valid bits and both matrix registers
// in_ready_o drops only once the output skid entry holds a word; stalls move no data
`timescale 1ns / 1ps

module burst_ecc_encode_decode import bece_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  data_t            data_word_i,
  input  code_t            received_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output code_t            code_word_out_o,
  output data_t            data_out_o,
  output logic [5:0]       syndrome_o,
  output logic             uncorrectable_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [REG_W-1:0] cfg_data_i
);

  logic [REG_W-1:0] h_low_q, h_high_q;
  cols_t            cols;
  logic             s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready;
  s1_t              s1;
  s2_t              s2;
  res_t             s3, res;

  assign cfg_ready_o = 1'b1;
  assign cols        = cols_from_regs(h_low_q, h_high_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_low_q  <= '0;
      h_high_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_reg_e'(cfg_index_i) == REG_H_LOW) begin
        h_low_q <= cfg_data_i;
      end else begin
        h_high_q <= cfg_data_i;
      end
    end
  end

  bece_syndrome u_syndrome (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cols_i          (cols),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .data_word_i     (data_word_i),
    .received_word_i (received_word_i),
    .out_valid_o     (s1_valid),
    .out_ready_i     (s1_ready),
    .out_o           (s1)
  );

  bece_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cols_i      (cols),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_i        (s1),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .out_o       (s2)
  );

  bece_correct u_correct (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .in_i        (s2),
    .out_valid_o (s3_valid),
    .out_ready_i (s3_ready),
    .out_o       (s3)
  );

  bece_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s3_valid),
    .in_ready_o  (s3_ready),
    .in_i        (s3),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign code_word_out_o = res.cword;
  assign data_out_o      = res.data;
  assign syndrome_o      = res.syndrome;
  assign uncorrectable_o = res.uncorrectable;

  a_unc_needs_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && uncorrectable_o |-> syndrome_o != '0)
    else $error("uncorrectable flagged with zero syndrome");

  a_s3_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid && !s3_ready |=> s3_valid && $stable(s3))
    else $error("stage 3 word lost during stall");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid && s2_valid && s3_valid && !s3_ready)
    else $error("input stalled with a free stage");

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for burst_ecc_encode_decode: directed table, then random bursts
// words are taken from the table or predicted per matrix setting and compared field by field in order
// depends on bece_pkg and the burst_ecc_encode_decode rtl
`timescale 1ns / 1ps

module testbench;
  import bece_pkg::*;

  localparam int NUM_DIR       = 20;
  localparam int FIRST_PREDICT = 7;
  localparam int NUM_PHASES    = 7;
  localparam int PHASE_WORDS   = 160;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic  fixed_want;
    cmd_e  cmd;
    data_t data;
    code_t recv;
    res_t  want;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             command_i;
  data_t            data_word_i;
  code_t            received_word_i;
  logic             out_valid_o;
  logic             out_ready_i;
  code_t            code_word_out_o;
  data_t            data_out_o;
  logic [5:0]       syndrome_o;
  logic             uncorrectable_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic             cfg_index_i;
  logic [REG_W-1:0] cfg_data_i;

  logic [REG_W-1:0] mat_lo;
  logic [REG_W-1:0] mat_hi;
  logic [REG_W-1:0] good_lo;
  logic [REG_W-1:0] good_hi;
  res_t             pending_results[$];
  int               errors;
  int               words_sent;
  int               words_checked;
  int               matrix_writes;
  bit               quiet_tx;
  bit               quiet_rx;

  col_t good_cols [CODE_BITS] = '{6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd32, 6'd3, 6'd6, 6'd12,
                                  6'd24, 6'd48, 6'd33, 6'd5, 6'd10, 6'd20, 6'd40, 6'd17,
                                  6'd34};

  // zero matrix rows first: every column matches a zero syndrome, so decode flips bits 0..2
  dir_row_t dir_rows [NUM_DIR] = '{
    '{1'b1, CMD_ENCODE, 12'h000, 18'h00000, '{18'h00000, 12'h000, 6'h00, 1'b0}},
    '{1'b1, CMD_ENCODE, 12'hfff, 18'h3ffff, '{18'h3ffc0, 12'h000, 6'h00, 1'b0}},
    '{1'b1, CMD_ENCODE, 12'h5a5, 18'h00000, '{18'h16940, 12'h000, 6'h00, 1'b0}},
    '{1'b1, CMD_DECODE, 12'hfff, 18'h00000, '{18'h00007, 12'h000, 6'h00, 1'b0}},
    '{1'b1, CMD_DECODE, 12'h000, 18'h3ffff, '{18'h3fff8, 12'hfff, 6'h00, 1'b0}},
    '{1'b1, CMD_DECODE, 12'h000, 18'h2aaaa, '{18'h2aaad, 12'haaa, 6'h00, 1'b0}},
    '{1'b1, CMD_DECODE, 12'h000, 18'h15555, '{18'h15552, 12'h555, 6'h00, 1'b0}},
    '{1'b0, CMD_ENCODE, 12'h000, 18'h00000, '0},
    '{1'b0, CMD_ENCODE, 12'hfff, 18'h00000, '0},
    '{1'b0, CMD_ENCODE, 12'h001, 18'h00000, '0},
    '{1'b0, CMD_ENCODE, 12'h800, 18'h00000, '0},
    '{1'b0, CMD_DECODE, 12'h000, 18'h00000, '0},
    '{1'b0, CMD_DECODE, 12'h000, 18'h00001, '0},
    '{1'b0, CMD_DECODE, 12'h000, 18'h00040, '0},
    '{1'b0, CMD_DECODE, 12'h000, 18'h000c0, '0},
    '{1'b0, CMD_DECODE, 12'h000, 18'h00140, '0},
    '{1'b0, CMD_DECODE, 12'h000, 18'h001c0, '0},
    '{1'b0, CMD_DECODE, 12'h000, 18'h3ffff, '0},
    '{1'b0, CMD_DECODE, 12'h000, 18'h20000, '0},
    '{1'b0, CMD_DECODE, 12'h000, 18'h30000, '0}
  };

  burst_ecc_encode_decode u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .data_word_i     (data_word_i),
    .received_word_i (received_word_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .code_word_out_o (code_word_out_o),
    .data_out_o      (data_out_o),
    .syndrome_o      (syndrome_o),
    .uncorrectable_o (uncorrectable_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("burst_ecc_encode_decode regression: fail");
    $finish;
  end

  function automatic col_t mat_col(input int k);
    if (k < COLS_PER_REG) begin
      return mat_lo[SLOT_W*k +: CHECK_BITS];
    end
    return mat_hi[SLOT_W*(k-COLS_PER_REG) +: CHECK_BITS];
  endfunction

  function automatic res_t codec_predict(input cmd_e cmd, input data_t d, input code_t r);
    res_t  x;
    code_t cw;
    code_t err;
    col_t  s;
    bit    hit;
    x = '0;
    s = '0;
    if (cmd == CMD_ENCODE) begin
      cw = {d, {CHECK_BITS{1'b0}}};
      for (int k = 0; k < CODE_BITS; k++) begin
        if (cw[k]) s ^= mat_col(k);
      end
      for (int i = 0; i < CHECK_BITS; i++) begin
        cw[i] = ^(mat_col(i) & s);
      end
      x.cword = cw;
      return x;
    end
    for (int k = 0; k < CODE_BITS; k++) begin
      if (r[k]) s ^= mat_col(k);
    end
    err = '0;
    hit = 1'b0;
    for (int i = 0; i < CODE_BITS && !hit; i++) begin
      if (mat_col(i) == s) begin
        err[i] = 1'b1;
        hit = 1'b1;
      end
    end
    hit = 1'b0;
    for (int i = 1; i < CODE_BITS && !hit; i++) begin
      if ((mat_col(i-1) ^ mat_col(i)) == s) begin
        err[i-1] = 1'b1;
        err[i]   = 1'b1;
        hit = 1'b1;
      end
    end
    hit = 1'b0;
    for (int i = 2; i < CODE_BITS && !hit; i++) begin
      if ((mat_col(i-2) ^ mat_col(i)) == s) begin
        err[i-2] = 1'b1;
        err[i]   = 1'b1;
        err[i-1] = 1'b0;
        hit = 1'b1;
      end
    end
    hit = 1'b0;
    for (int i = 2; i < CODE_BITS && !hit; i++) begin
      if ((mat_col(i-2) ^ mat_col(i-1) ^ mat_col(i)) == s) begin
        err[i-2 +: 3] = 3'b111;
        hit = 1'b1;
      end
    end
    cw = r ^ err;
    x.cword         = cw;
    x.data          = cw[CODE_BITS-1:CHECK_BITS];
    x.syndrome      = s;
    x.uncorrectable = (err[CODE_BITS-1:CHECK_BITS] == '0) && (s != '0);
    return x;
  endfunction

  function automatic void check_field(input string what, input logic [17:0] want,
                                      input logic [17:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endfunction

  task automatic send_word(input cmd_e cmd, input data_t d, input code_t r, input res_t want);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    data_word_i     <= d;
    received_word_i <= r;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    pending_results.push_back(want);
    words_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_matrix(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_H_LOW;
    cfg_data_i  <= lo;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    mat_lo = lo;
    cfg_index_i <= REG_H_HIGH;
    cfg_data_i  <= hi;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    mat_hi = hi;
    cfg_valid_i <= 1'b0;
    matrix_writes += 2;
  endtask

  task automatic send_random();
    cmd_e  cmd;
    data_t d;
    code_t r;
    code_t burst;
    res_t  clean;
    int    pick;
    logic [2:0] pat;
    d = data_t'($urandom);
    r = code_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      cmd = CMD_ENCODE;
    end else begin
      cmd = CMD_DECODE;
      if (pick < 80) begin
        // clean code word hit by a burst of one of the correctable shapes, or left clean
        case ($urandom_range(0, 4))
          0: pat = 3'b000;
          1: pat = 3'b001;
          2: pat = 3'b011;
          3: pat = 3'b101;
          default: pat = 3'b111;
        endcase
        burst = code_t'(pat) << $urandom_range(0, CODE_BITS - 1);
        clean = codec_predict(CMD_ENCODE, d, '0);
        r = clean.cword ^ burst;
        d = data_t'($urandom);
      end
    end
    send_word(cmd, d, r, codec_predict(cmd, d, r));
  endtask

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      int n;
      n = quiet_rx ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h %h %h %b", $time,
                 code_word_out_o, data_out_o, syndrome_o, uncorrectable_o);
      end else begin
        want = pending_results.pop_front();
        check_field("code word", want.cword, code_word_out_o);
        check_field("data bits", want.data, data_out_o);
        check_field("syndrome", want.syndrome, syndrome_o);
        check_field("uncorrectable", want.uncorrectable, uncorrectable_o);
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    command_i       = CMD_ENCODE;
    data_word_i     = '0;
    received_word_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_H_LOW;
    cfg_data_i      = '0;
    mat_lo          = '0;
    mat_hi          = '0;
    errors          = 0;
    words_sent      = 0;
    words_checked   = 0;
    matrix_writes   = 0;
    quiet_tx        = 1'b0;
    quiet_rx        = 1'b0;
    for (int k = 0; k < COLS_PER_REG; k++) begin
      good_lo[SLOT_W*k +: SLOT_W] = good_cols[k];
      good_hi[SLOT_W*k +: SLOT_W] = good_cols[COLS_PER_REG+k];
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) begin
      if (i == FIRST_PREDICT) begin
        settle();
        write_matrix(good_lo, good_hi);
      end
      send_word(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].recv,
                dir_rows[i].fixed_want ? dir_rows[i].want
                : codec_predict(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].recv));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          write_matrix(good_lo, good_hi);
        end
        1: begin
          write_matrix({REG_W{1'b1}}, {REG_W{1'b1}});
        end
        2: begin
          write_matrix({REG_W{1'b1}}, '0);
        end
        3: begin
          write_matrix('0, {REG_W{1'b1}});
        end
        6: begin
          write_matrix(good_lo, good_hi);
        end
        default: begin
          write_matrix(REG_W'({$urandom, $urandom}), REG_W'({$urandom, $urandom}));
        end
      endcase
      quiet_tx = (p == 2) || (p == 6);
      quiet_rx = (p == 4) || (p == 6);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // sender holds off mid-phase until the pipe has drained
        if (n == PHASE_WORDS / 2) settle();
        send_random();
      end
    end

    settle();
    $display("covered %0d words in, %0d words out, %0d matrix register writes",
             words_sent, words_checked, matrix_writes);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("burst_ecc_encode_decode regression: pass");
    end else begin
      $display("%0d mismatches, %0d words never seen", errors, pending_results.size());
      $display("burst_ecc_encode_decode regression: fail");
    end
    $finish;
  end

endmodule
